// ===== src/differential_thermostat_control_macros.svh =====
`ifndef DIFFERENTIAL_THERMOSTAT_CONTROL_MACROS_SVH
`define DIFFERENTIAL_THERMOSTAT_CONTROL_MACROS_SVH

// same-cycle implication, checked outside reset
`define DTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DTC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dtc_pkg.sv =====
`timescale 1ns / 1ps

package dtc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic OP_READING = 1'b0;
    localparam logic OP_CONTROL = 1'b1;

    typedef enum logic [2:0] {
        REG_DELTA_ON       = 3'd0,
        REG_DELTA_OFF      = 3'd1,
        REG_LIMIT_HYS      = 3'd2,
        REG_MIN_SOURCE     = 3'd3,
        REG_MAX_TANK       = 3'd4,
        REG_FAILSAFE       = 3'd5,
        REG_POLARITY       = 3'd6,
        REG_CONFIGURED     = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_AUTO       = 2'd0,
        MODE_MANUAL_OFF = 2'd1,
        MODE_MANUAL_ON  = 2'd2,
        MODE_FAILSAFE   = 2'd3
    } mode_t;

    localparam int FLAG_NO_CONFIG  = 0;
    localparam int FLAG_SRC_FAULT  = 1;
    localparam int FLAG_TANK_FAULT = 2;
    localparam int FLAG_FALLBACK   = 3;
    localparam int FLAG_MIN_LIMIT  = 4;
    localparam int FLAG_MAX_LIMIT  = 5;

    localparam logic signed [15:0] PLAUS_LOW       = -16'sd5500;
    localparam logic signed [15:0] PLAUS_HIGH      = 16'sd12500;
    localparam logic signed [15:0] EXCLUDE_LOW     = 16'sd8499;
    localparam logic signed [15:0] EXCLUDE_HIGH    = 16'sd8501;
    localparam logic [13:0]        LIMIT_MAX       = 14'd9500;
    localparam logic [13:0]        TMIN_DEFAULT    = 14'd3000;
    localparam logic [13:0]        TMAX_DEFAULT    = 14'd7000;
    localparam logic signed [17:0] DELTA_OFF_MARGIN = 18'sd10;

    typedef struct packed {
        logic               operation;
        logic [31:0]        now_ms;
        logic signed [15:0] reading_source;
        logic signed [15:0] reading_tank;
        logic               auto_mode;
        logic               manual_level;
    } in_t;

    typedef struct packed {
        logic               output_on;
        logic               relay_pin;
        logic [5:0]         alarm_bits;
        logic [1:0]         mode_code;
        logic               difference_valid;
        logic signed [15:0] difference;
    } out_t;

    typedef struct packed {
        logic [11:0]        delta_on;
        logic signed [12:0] delta_off;
        logic [9:0]         limit_hysteresis;
        logic [13:0]        min_source_temp;
        logic [13:0]        max_tank_temp;
        logic               failsafe_level;
        logic               relay_polarity_high;
        logic               sensors_configured;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        delta_on:            12'd200,
        delta_off:           13'sd50,
        limit_hysteresis:    10'd50,
        min_source_temp:     14'd3000,
        max_tank_temp:       14'd7000,
        failsafe_level:      1'b1,
        relay_polarity_high: 1'b1,
        sensors_configured:  1'b0
    };

    typedef struct packed {
        logic output_state;
        logic min_blocked;
        logic max_blocked;
    } ctl_state_t;

    function automatic logic plausible(input logic signed [15:0] t);
        plausible = (t >= PLAUS_LOW) && (t <= PLAUS_HIGH) &&
                    !((t >= EXCLUDE_LOW) && (t <= EXCLUDE_HIGH));
    endfunction

endpackage

// ===== src/dtc_regs.sv =====
`timescale 1ns / 1ps

module dtc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [dtc_pkg::ADDR_W-1:0] paddr,
    input  logic [dtc_pkg::DATA_W-1:0] pwdata,
    output logic [dtc_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output dtc_pkg::cfg_t             cfg
);

    dtc_pkg::cfg_t       cfg_reg;
    dtc_pkg::cfg_t       cfg_next;
    dtc_pkg::reg_index_t idx;
    logic                wr_en;

    assign idx    = dtc_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                dtc_pkg::REG_DELTA_ON:   cfg_next.delta_on            = pwdata[11:0];
                dtc_pkg::REG_DELTA_OFF:  cfg_next.delta_off           = pwdata[12:0];
                dtc_pkg::REG_LIMIT_HYS:  cfg_next.limit_hysteresis    = pwdata[9:0];
                dtc_pkg::REG_MIN_SOURCE: cfg_next.min_source_temp     = pwdata[13:0];
                dtc_pkg::REG_MAX_TANK:   cfg_next.max_tank_temp       = pwdata[13:0];
                dtc_pkg::REG_FAILSAFE:   cfg_next.failsafe_level      = pwdata[0];
                dtc_pkg::REG_POLARITY:   cfg_next.relay_polarity_high = pwdata[0];
                dtc_pkg::REG_CONFIGURED: cfg_next.sensors_configured  = pwdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= dtc_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            dtc_pkg::REG_DELTA_ON:   prdata = {20'd0, cfg_reg.delta_on};
            dtc_pkg::REG_DELTA_OFF:  prdata = {19'd0, cfg_reg.delta_off};
            dtc_pkg::REG_LIMIT_HYS:  prdata = {22'd0, cfg_reg.limit_hysteresis};
            dtc_pkg::REG_MIN_SOURCE: prdata = {18'd0, cfg_reg.min_source_temp};
            dtc_pkg::REG_MAX_TANK:   prdata = {18'd0, cfg_reg.max_tank_temp};
            dtc_pkg::REG_FAILSAFE:   prdata = {31'd0, cfg_reg.failsafe_level};
            dtc_pkg::REG_POLARITY:   prdata = {31'd0, cfg_reg.relay_polarity_high};
            dtc_pkg::REG_CONFIGURED: prdata = {31'd0, cfg_reg.sensors_configured};
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== src/dtc_eval.sv =====
`timescale 1ns / 1ps

module dtc_eval (
    input  dtc_pkg::in_t               item,
    input  dtc_pkg::cfg_t              cfg,
    input  logic [1:0]                 sensor_ok,
    input  logic signed [15:0]         t_source,
    input  logic signed [15:0]         t_tank,
    input  dtc_pkg::ctl_state_t        state,
    output dtc_pkg::ctl_state_t        state_next,
    output dtc_pkg::out_t              result
);

    logic               fault;
    logic               both_ok;
    logic [13:0]        tmin;
    logic [13:0]        tmax;
    logic signed [17:0] t1;
    logic signed [17:0] t2;
    logic signed [17:0] tmin_s;
    logic signed [17:0] tmax_s;
    logic signed [17:0] hys_s;
    logic signed [17:0] don_s;
    logic signed [17:0] doff_raw;
    logic signed [17:0] doff;
    logic signed [17:0] d;
    logic               nb_min;
    logic               nb_max;
    logic               desired;
    logic [5:0]         alarm;
    dtc_pkg::mode_t     mode;

    assign both_ok  = sensor_ok[0] && sensor_ok[1];
    assign fault    = !both_ok;
    assign tmin     = (cfg.min_source_temp > dtc_pkg::LIMIT_MAX) ?
                      dtc_pkg::TMIN_DEFAULT : cfg.min_source_temp;
    assign tmax     = (cfg.max_tank_temp > dtc_pkg::LIMIT_MAX) ?
                      dtc_pkg::TMAX_DEFAULT : cfg.max_tank_temp;
    assign t1       = {{2{t_source[15]}}, t_source};
    assign t2       = {{2{t_tank[15]}}, t_tank};
    assign tmin_s   = {4'd0, tmin};
    assign tmax_s   = {4'd0, tmax};
    assign hys_s    = {8'd0, cfg.limit_hysteresis};
    assign don_s    = {6'd0, cfg.delta_on};
    assign doff_raw = {{5{cfg.delta_off[12]}}, cfg.delta_off};
    assign doff     = (doff_raw >= don_s) ? (don_s - dtc_pkg::DELTA_OFF_MARGIN) : doff_raw;
    assign d        = t1 - t2;

    assign nb_min = state.min_blocked ? !(t1 >= tmin_s + hys_s) : (t1 < tmin_s);
    assign nb_max = state.max_blocked ? !(t2 <= tmax_s - hys_s) : (t2 >= tmax_s);

    always_comb
    begin
        state_next = state;
        alarm      = '0;
        desired    = state.output_state;
        if (!cfg.sensors_configured)
        begin
            alarm[dtc_pkg::FLAG_NO_CONFIG] = 1'b1;
            desired = 1'b0;
        end
        else if (!item.auto_mode)
        begin
            desired = item.manual_level;
        end
        else if (fault)
        begin
            alarm[dtc_pkg::FLAG_SRC_FAULT]  = !sensor_ok[0];
            alarm[dtc_pkg::FLAG_TANK_FAULT] = !sensor_ok[1];
            alarm[dtc_pkg::FLAG_FALLBACK]   = 1'b1;
            desired = cfg.failsafe_level;
        end
        else
        begin
            state_next.min_blocked = nb_min;
            state_next.max_blocked = nb_max;
            if (nb_min)
            begin
                alarm[dtc_pkg::FLAG_MIN_LIMIT] = 1'b1;
                desired = 1'b0;
            end
            else if (nb_max)
            begin
                alarm[dtc_pkg::FLAG_MAX_LIMIT] = 1'b1;
                desired = 1'b0;
            end
            else if (d >= don_s)
            begin
                desired = 1'b1;
            end
            else if (d <= doff)
            begin
                desired = 1'b0;
            end
        end
        state_next.output_state = desired;
    end

    always_comb
    begin
        if (item.auto_mode)
        begin
            mode = fault ? dtc_pkg::MODE_FAILSAFE : dtc_pkg::MODE_AUTO;
        end
        else
        begin
            mode = item.manual_level ? dtc_pkg::MODE_MANUAL_ON : dtc_pkg::MODE_MANUAL_OFF;
        end
    end

    always_comb
    begin
        result.output_on        = desired;
        result.relay_pin        = cfg.relay_polarity_high ? desired : !desired;
        result.alarm_bits       = alarm;
        result.mode_code        = mode;
        result.difference_valid = both_ok;
        result.difference       = both_ok ? d[15:0] : 16'sd0;
    end

endmodule

// ===== src/differential_thermostat_control.sv =====
// Differential thermostat with hysteresis on signed centidegree readings. A reading transaction
// (operation 0) stores each plausible sensor value with its timestamp and returns nothing; a
// control transaction (operation 1) returns one result: logical output, relay level, alarm
// mask, mode and the source minus tank difference. One transaction is accepted per cycle while
// in_stall is low; a control result passes through the input register and the result register
// around a single pass of compare logic. While the result register is stalled, a control
// transaction waits in the input register and the input stalls behind it, but reading
// transactions still drain. A sensor counts as valid for STALE_MS milliseconds after its last
// plausible reading, by wrapping 32-bit time. The user writes configuration through the APB
// port only while no transaction is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module differential_thermostat_control #(
    parameter int unsigned STALE_MS = 12000
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  dtc_pkg::in_t               in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output dtc_pkg::out_t              out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dtc_pkg::ADDR_W-1:0] paddr,
    input  logic [dtc_pkg::DATA_W-1:0] pwdata,
    output logic [dtc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    dtc_pkg::cfg_t       cfg;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    dtc_pkg::in_t        s1_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    dtc_pkg::out_t       out_data_reg;
    logic signed [15:0]  temp_reg [2];
    logic [31:0]         time_reg [2];
    logic [1:0]          present_reg;
    logic [1:0]          present_next;
    dtc_pkg::ctl_state_t ctl_reg;
    dtc_pkg::ctl_state_t ctl_next;
    dtc_pkg::ctl_state_t eval_state;
    dtc_pkg::out_t       eval_result;
    logic                in_accept;
    logic                s1_adv;
    logic                s1_is_ctl;
    logic [1:0]          store_en;
    logic [1:0]          sensor_ok;
    logic [31:0]         age [2];

    dtc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_is_ctl = (s1_data_reg.operation == dtc_pkg::OP_CONTROL);
    assign s1_adv    = s1_valid_reg && (!s1_is_ctl || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign age[0]       = s1_data_reg.now_ms - time_reg[0];
    assign age[1]       = s1_data_reg.now_ms - time_reg[1];
    assign sensor_ok[0] = present_reg[0] && (age[0] < 32'(STALE_MS));
    assign sensor_ok[1] = present_reg[1] && (age[1] < 32'(STALE_MS));

    dtc_eval u_eval (
        .item       (s1_data_reg),
        .cfg        (cfg),
        .sensor_ok  (sensor_ok),
        .t_source   (temp_reg[0]),
        .t_tank     (temp_reg[1]),
        .state      (ctl_reg),
        .state_next (eval_state),
        .result     (eval_result)
    );

    always_comb
    begin
        store_en[0] = s1_adv && !s1_is_ctl && dtc_pkg::plausible(s1_data_reg.reading_source);
        store_en[1] = s1_adv && !s1_is_ctl && dtc_pkg::plausible(s1_data_reg.reading_tank);
        present_next = present_reg | store_en;
        ctl_next     = (s1_adv && s1_is_ctl) ? eval_state : ctl_reg;

        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_adv && s1_is_ctl)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            present_reg   <= 2'b00;
            ctl_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            present_reg   <= present_next;
            ctl_reg       <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_adv && s1_is_ctl)
        begin
            out_data_reg <= eval_result;
        end
        if (store_en[0])
        begin
            temp_reg[0] <= s1_data_reg.reading_source;
            time_reg[0] <= s1_data_reg.now_ms;
        end
        if (store_en[1])
        begin
            temp_reg[1] <= s1_data_reg.reading_tank;
            time_reg[1] <= s1_data_reg.now_ms;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/dtc_checker.sv =====
`timescale 1ns / 1ps
`include "differential_thermostat_control_macros.svh"

module dtc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_stall,
    input dtc_pkg::out_t out_data
);

    logic held;
    logic no_diff;
    logic blocked;
    logic in_auto;
    logic fallback;
    logic in_failsafe;

    assign held        = out_valid && out_stall;
    assign no_diff     = out_valid && !out_data.difference_valid;
    assign blocked     = out_valid && (out_data.alarm_bits[dtc_pkg::FLAG_NO_CONFIG] ||
                                       out_data.alarm_bits[dtc_pkg::FLAG_MIN_LIMIT] ||
                                       out_data.alarm_bits[dtc_pkg::FLAG_MAX_LIMIT]);
    assign in_auto     = out_valid && (out_data.mode_code == dtc_pkg::MODE_AUTO);
    assign fallback    = out_valid && out_data.alarm_bits[dtc_pkg::FLAG_FALLBACK];
    assign in_failsafe = (out_data.mode_code == dtc_pkg::MODE_FAILSAFE);

    `DTC_ASSERT_NXT(a_out_hold, held, out_valid && $stable(out_data), "stalled result changed")

    `DTC_ASSERT_IMP(a_diff_zero, no_diff, out_data.difference == 16'sd0, "stray difference")

    `DTC_ASSERT_IMP(a_block_off, blocked, !out_data.output_on, "output on while blocked")

    `DTC_ASSERT_IMP(a_auto_valid, in_auto, out_data.difference_valid, "auto without sensors")

    `DTC_ASSERT_IMP(a_failsafe_mode, fallback, in_failsafe, "failsafe alarm in wrong mode")

endmodule

bind differential_thermostat_control dtc_checker u_dtc_checker (.*);
